[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/gfph_pkg.sv]
// Types and constants of the GNSS fix to pose and heading block.
package gfph_pkg;
	localparam int unsigned EastW  = 30;
	localparam int unsigned NorthW = 34;
	localparam int unsigned HdopW  = 14;
	localparam int unsigned PosW   = 35;
	localparam int unsigned VarW   = 30;
	localparam int unsigned CfgW   = 20;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CordicSteps = 30;
	localparam int unsigned CordicW = 46;
	localparam logic [HdopW-1:0] HdopGoodLimit = 14'd200;

	localparam logic [CfgIdxW-1:0] RegRelMode = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSettle  = 2'd1;
	localparam logic [CfgIdxW-1:0] RegThresh  = 2'd2;
	localparam logic [CfgIdxW-1:0] RegGain    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_WAIT,
		ST_CMP,
		ST_NORM,
		ST_CORD,
		ST_WRITE,
		ST_OUT
	} state_t;

	function automatic logic [31:0] turn_angle(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
			default: r = 32'h0;
		endcase
		return r;
	endfunction
endpackage

[src/gfph_fix_if.sv]
// Handshake channels for fixes and pose results.
interface gfph_fix_if;
	logic                           valid;
	logic                           ready;
	logic [gfph_pkg::EastW-1:0]     east_mm;
	logic [gfph_pkg::NorthW-1:0]    north_mm;
	logic [gfph_pkg::HdopW-1:0]     hdop_centi;
	modport source (output valid, east_mm, north_mm, hdop_centi, input ready);
	modport sink   (input valid, east_mm, north_mm, hdop_centi, output ready);
endinterface

interface gfph_pose_if;
	logic                           valid;
	logic                           ready;
	logic signed [gfph_pkg::PosW-1:0] pos_x_mm;
	logic signed [gfph_pkg::PosW-1:0] pos_y_mm;
	logic signed [15:0]             heading_angle;
	logic                           heading_valid;
	logic [gfph_pkg::VarW-1:0]      position_variance;
	modport source (output valid, pos_x_mm, pos_y_mm, heading_angle, heading_valid,
		position_variance, input ready);
	modport sink   (input valid, pos_x_mm, pos_y_mm, heading_angle, heading_valid,
		position_variance, output ready);
endinterface

[src/gfph_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module gfph_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

[src/gnss_fix_to_pose_heading.sv]
// GNSS fix to pose and heading: top level with its sequencer and shared datapath.
// One fix at a time. A fix before settling returns to idle without a result.
// A settled fix is written and output directly while the history fills; with a full
// history the block walks the older points newest first through one shared
// squared-distance compare, a square step and a compare step a point, until one
// lies beyond the threshold. Only then follow a normalising shift and iterative
// CORDIC rotations on a single add/subtract datapath; otherwise heading_valid stays
// low. The history RAM is not cleared; it is read only once full.
`include "assert_macros.svh"
module gnss_fix_to_pose_heading #(
	parameter int unsigned HISTORY_DEPTH = 25,
	parameter int unsigned ANGLE_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	gfph_fix_if.sink                      fix_in,
	gfph_pose_if.source                   pose_out,
	input  logic                          cfg_we,
	input  logic [gfph_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [gfph_pkg::CfgW-1:0]     cfg_data
);
	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned HW = gfph_pkg::EastW + gfph_pkg::NorthW;
	localparam int unsigned CW = gfph_pkg::CordicW;

	gfph_pkg::state_t state_q, state_d;

	logic                         rel_q;
	logic [7:0]                   settle_q;
	logic [19:0]                  thr_q;
	logic [15:0]                  gain_q;
	logic                         settled_q;
	logic [7:0]                   good_q;
	logic [gfph_pkg::EastW-1:0]   ref_e_q;
	logic [gfph_pkg::NorthW-1:0]  ref_n_q;
	logic [FW-1:0]                fill_q;
	logic [AW-1:0]                head_q;
	logic [AW-1:0]                rd_q;
	logic [FW-1:0]                k_q;
	logic [15:0]                  head_ang_q;
	logic                         hv_q;
	logic [gfph_pkg::EastW-1:0]   e_q;
	logic [gfph_pkg::NorthW-1:0]  n_q;
	logic [gfph_pkg::HdopW-1:0]   h_q;
	logic [HW-1:0]                rdata;
	logic [63:0]                  sx_q, sy_q;
	logic signed [CW-1:0]         x_q, y_q;
	logic [31:0]                  z_q;
	logic [4:0]                   it_q;
	logic                         ov_q;
	logic signed [gfph_pkg::PosW-1:0] px_q, py_q;
	logic [gfph_pkg::VarW-1:0]    var_q;

	// history entry fields and differences
	logic [gfph_pkg::EastW-1:0]   he;
	logic [gfph_pkg::NorthW-1:0]  hn;
	logic [gfph_pkg::NorthW-1:0]  adx, ady;
	logic signed [gfph_pkg::NorthW:0] dx, dy;
	logic [64:0]                  dsum;
	logic [63:0]                  d2, thr2;
	logic [CW-1:0]                ax, ay, mag;
	logic signed [CW-1:0]         xs, ys;
	logic [31:0]                  rnd;
	logic [ANGLE_BITS-1:0]        ang;

	assign he = rdata[HW-1 -: gfph_pkg::EastW];
	assign hn = rdata[gfph_pkg::NorthW-1:0];
	assign dx = $signed({{(gfph_pkg::NorthW-gfph_pkg::EastW+1){1'b0}}, e_q})
		- $signed({{(gfph_pkg::NorthW-gfph_pkg::EastW+1){1'b0}}, he});
	assign dy = $signed({1'b0, n_q}) - $signed({1'b0, hn});
	assign adx = dx[gfph_pkg::NorthW] ? gfph_pkg::NorthW'(-dx) : dx[gfph_pkg::NorthW-1:0];
	assign ady = dy[gfph_pkg::NorthW] ? gfph_pkg::NorthW'(-dy) : dy[gfph_pkg::NorthW-1:0];
	assign dsum = {1'b0, sx_q} + {1'b0, sy_q};
	assign d2 = (ov_q || dsum[64]) ? '1 : dsum[63:0];
	assign thr2 = 64'(thr_q) * 64'(thr_q);
	assign ax = x_q[CW-1] ? CW'(-x_q) : CW'(x_q);
	assign ay = y_q[CW-1] ? CW'(-y_q) : CW'(y_q);
	assign mag = (ax > ay) ? ax : ay;
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign rnd = z_q + (32'd1 << (31 - ANGLE_BITS));
	assign ang = rnd[31 -: ANGLE_BITS];

	gfph_ram #(.WIDTH(HW), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk   (clk),
		.we    (state_q == gfph_pkg::ST_WRITE),
		.waddr (head_q),
		.wdata ({e_q, n_q}),
		.raddr (rd_q),
		.rdata (rdata)
	);

	assign fix_in.ready = (state_q == gfph_pkg::ST_IDLE);
	assign pose_out.valid = (state_q == gfph_pkg::ST_OUT);
	assign pose_out.pos_x_mm = px_q;
	assign pose_out.pos_y_mm = py_q;
	assign pose_out.heading_angle = head_ang_q;
	assign pose_out.heading_valid = hv_q;
	assign pose_out.position_variance = var_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfph_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gfph_pkg::ST_IDLE:  if (fix_in.valid) state_d = gfph_pkg::ST_RD;
			gfph_pkg::ST_RD: begin
				if (!settled_q)
					state_d = gfph_pkg::ST_IDLE;
				else if (fill_q >= FW'(HISTORY_DEPTH - 1))
					state_d = gfph_pkg::ST_WAIT;
				else
					state_d = gfph_pkg::ST_WRITE;
			end
			gfph_pkg::ST_WAIT:  state_d = gfph_pkg::ST_CMP;
			gfph_pkg::ST_CMP: begin
				if (d2 > thr2)
					state_d = gfph_pkg::ST_NORM;
				else if (k_q == FW'(HISTORY_DEPTH - 1))
					state_d = gfph_pkg::ST_WRITE;
				else
					state_d = gfph_pkg::ST_WAIT;
			end
			gfph_pkg::ST_NORM:
				if (mag == '0 || mag[40]) state_d = gfph_pkg::ST_CORD;
			gfph_pkg::ST_CORD:
				if (it_q == 5'(gfph_pkg::CordicSteps - 1)) state_d = gfph_pkg::ST_WRITE;
			gfph_pkg::ST_WRITE: state_d = gfph_pkg::ST_OUT;
			gfph_pkg::ST_OUT:   if (pose_out.ready) state_d = gfph_pkg::ST_IDLE;
			default:            state_d = gfph_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q      <= 1'b0;
			settle_q   <= 8'd3;
			thr_q      <= 20'd1000;
			gain_q     <= 16'd256;
			settled_q  <= 1'b0;
			good_q     <= '0;
			ref_e_q    <= '0;
			ref_n_q    <= '0;
			fill_q     <= '0;
			head_q     <= '0;
			head_ang_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gfph_pkg::RegRelMode: rel_q    <= cfg_data[0];
					gfph_pkg::RegSettle:  settle_q <= cfg_data[7:0];
					gfph_pkg::RegThresh:  thr_q    <= cfg_data;
					gfph_pkg::RegGain:    gain_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == gfph_pkg::ST_RD && !settled_q && h_q < gfph_pkg::HdopGoodLimit) begin
				if (good_q != 8'hFF)
					good_q <= good_q + 8'd1;
				if ((good_q != 8'hFF ? good_q + 8'd1 : good_q) >= settle_q) begin
					settled_q <= 1'b1;
					ref_e_q   <= e_q;
					ref_n_q   <= n_q;
				end
			end
			if (state_q == gfph_pkg::ST_RD && settled_q && fill_q != FW'(HISTORY_DEPTH))
				fill_q <= fill_q + FW'(1);
			if (state_q == gfph_pkg::ST_WRITE)
				head_q <= (head_q == AW'(HISTORY_DEPTH - 1)) ? '0 : head_q + AW'(1);
			// round the finished angle once all rotations are in
			if (state_q == gfph_pkg::ST_WRITE && hv_q)
				head_ang_q <= 16'($signed(ang));
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			gfph_pkg::ST_IDLE: begin
				e_q  <= fix_in.east_mm;
				n_q  <= fix_in.north_mm;
				h_q  <= fix_in.hdop_centi;
				hv_q <= 1'b0;
				k_q  <= FW'(1);
				rd_q <= (head_q == '0) ? AW'(HISTORY_DEPTH - 1) : head_q - AW'(1);
			end
			gfph_pkg::ST_WAIT: begin
				// square both axes of the point just read, advance the read address
				ov_q <= (adx[gfph_pkg::NorthW-1:32] != '0) || (ady[gfph_pkg::NorthW-1:32] != '0);
				sx_q <= 64'(adx[31:0]) * 64'(adx[31:0]);
				sy_q <= 64'(ady[31:0]) * 64'(ady[31:0]);
				x_q  <= CW'(dx);
				y_q  <= CW'(dy);
				rd_q <= (rd_q == '0) ? AW'(HISTORY_DEPTH - 1) : rd_q - AW'(1);
			end
			gfph_pkg::ST_CMP: begin
				k_q  <= k_q + FW'(1);
				z_q  <= '0;
				it_q <= '0;
			end
			gfph_pkg::ST_NORM: begin
				if (!(mag == '0 || mag[40])) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else if (x_q < 0) begin
					x_q <= -x_q;
					y_q <= -y_q;
					z_q <= 32'h80000000;
				end
			end
			gfph_pkg::ST_CORD: begin
				it_q <= it_q + 5'd1;
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + gfph_pkg::turn_angle(it_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - gfph_pkg::turn_angle(it_q);
				end
				if (it_q == 5'(gfph_pkg::CordicSteps - 1))
					hv_q <= 1'b1;
			end
			gfph_pkg::ST_WRITE: begin
				if (rel_q) begin
					px_q <= gfph_pkg::PosW'({5'd0, e_q}) - gfph_pkg::PosW'({5'd0, ref_e_q});
					py_q <= gfph_pkg::PosW'({1'b0, n_q}) - gfph_pkg::PosW'({1'b0, ref_n_q});
				end else begin
					px_q <= gfph_pkg::PosW'({5'd0, e_q});
					py_q <= gfph_pkg::PosW'({1'b0, n_q});
				end
				var_q <= gfph_pkg::VarW'(h_q) * gfph_pkg::VarW'(gain_q);
			end
			default: ;
		endcase
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, fix_in.ready, !pose_out.valid,
		"input taken while a result waits")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, pose_out.valid && !pose_out.ready,
		pose_out.valid && $stable(pose_out.pos_x_mm), "result dropped while stalled")
	`ASSERT_IMPL(a_out_settled, clk, arst_n, pose_out.valid, settled_q,
		"result before settling")
	`ASSERT_IMPL(a_cmp_full, clk, arst_n, state_q == gfph_pkg::ST_CMP,
		fill_q == FW'(HISTORY_DEPTH), "history compared before full")
endmodule
